// ----- hdl/structure_consensus_table_assert.svh -----
// Assertion macros used by the top module of the consensus table.
`ifndef STRUCTURE_CONSENSUS_TABLE_ASSERT_SVH
`define STRUCTURE_CONSENSUS_TABLE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sct_pkg.sv -----
package sct_pkg;

  localparam int SCT_MAX_SCAFFOLDS = 16;

  localparam logic [2:0] TYPE_OTHER = 3'd0;
  localparam logic [2:0] TYPE_BETA  = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_NO_PARTNER = 2'd2
  } status_e;

  // One table entry as held in the label memory.
  typedef struct packed {
    logic [2:0]  lbl_type;
    logic [13:0] partner_one;
    logic        anti_one;
    logic [13:0] partner_two;
    logic        anti_two;
    logic [7:0]  sheet;
  } label_t;

  // Control from the sequencer to the label memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr;
  } tbl_ctl_t;

  // Two labels agree when their types match and, for beta, their partner data.
  function automatic logic same_label(label_t a, label_t b);
    logic same;
    same = (a.lbl_type == b.lbl_type);
    if (same && (a.lbl_type == TYPE_BETA)) begin
      same = (a.partner_one == b.partner_one) && (a.anti_one == b.anti_one) &&
             (a.partner_two == b.partner_two) && (a.anti_two == b.anti_two);
    end
    return same;
  endfunction

endpackage

// ----- hdl/sct_table.sv -----
module sct_table #(
  parameter int MaxScaffolds = sct_pkg::SCT_MAX_SCAFFOLDS,
  localparam int AddrW = (MaxScaffolds > 1) ? $clog2(MaxScaffolds) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sct_pkg::tbl_ctl_t ctl_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  sct_pkg::label_t   wr_data_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output sct_pkg::label_t   rd_data_o
);
  import sct_pkg::*;

  label_t                  mem_q [MaxScaffolds];
  logic [MaxScaffolds-1:0] valid_q;
  label_t                  rd_data_q;
  logic                    rd_valid_q;

  // Payload storage, one write and one read port, registered read data.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // An entry that was never written since reset or the last clear reads as OTHER.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- hdl/sct_scan.sv -----
module sct_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            init_i,
  input  logic            take_i,
  input  sct_pkg::label_t entry_i,
  output logic            consistent_o,
  output sct_pkg::label_t consensus_o
);
  import sct_pkg::*;

  logic   found_q, found_d;
  logic   agree_q, agree_d;
  label_t cons_q, cons_d;

  // The first non-OTHER entry becomes the candidate; any later mismatch
  // clears agreement.
  always_comb begin
    found_d = found_q;
    agree_d = agree_q;
    cons_d  = cons_q;
    if (init_i) begin
      found_d = 1'b0;
      agree_d = 1'b1;
      cons_d  = '0;
    end else if (take_i && (entry_i.lbl_type != TYPE_OTHER)) begin
      if (!found_q) begin
        found_d = 1'b1;
        cons_d  = entry_i;
      end else if (!same_label(cons_q, entry_i)) begin
        agree_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      agree_q <= 1'b1;
    end else begin
      found_q <= found_d;
      agree_q <= agree_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cons_q <= cons_d;
  end

  assign consistent_o = agree_q;
  assign consensus_o  = agree_q ? cons_q : '0;

endmodule

// ----- hdl/structure_consensus_table.sv -----
// Secondary-structure consensus table for one residue. The block holds one
// label per scaffold in a small synchronous memory and answers every input
// beat with exactly one result beat. A clear beat (kind 0) marks all entries
// OTHER at once; a store beat (kind 1) checks the index against the scaffold
// count and rejects a beta label with neither partner, otherwise writes the
// entry. In both cases the block then reads the first n entries back, one per
// cycle through the memory's single read port, and reports whether all
// non-OTHER entries agree together with the first such entry. Here n is the
// configured scaffold count, limited to MaxScaffolds and to thirty-one.
// From acceptance to the next possible acceptance a beat passes the accept
// and write step, the n reads, the step in which the last read data is
// folded in, and the step that loads the result register. A result waiting
// at the output does not hold up the next input beat; the scan stalls only
// when it finishes while the previous result is still untaken.
module structure_consensus_table #(
  parameter int MaxScaffolds = sct_pkg::SCT_MAX_SCAFFOLDS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration.
  input  logic        scaffold_count_we_i,
  input  logic [4:0]  scaffold_count_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [3:0]  entry_index_i,
  input  logic [2:0]  label_type_i,
  input  logic [13:0] partner_one_i,
  input  logic        antiparallel_one_i,
  input  logic [13:0] partner_two_i,
  input  logic        antiparallel_two_i,
  input  logic [7:0]  sheet_label_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        consistent_o,
  output logic [2:0]  consensus_type_o,
  output logic [13:0] consensus_partner_one_o,
  output logic        consensus_anti_one_o,
  output logic [13:0] consensus_partner_two_o,
  output logic        consensus_anti_two_o,
  output logic [7:0]  consensus_sheet_o
);
  import sct_pkg::*;

  localparam int AddrW  = (MaxScaffolds > 1) ? $clog2(MaxScaffolds) : 1;
  // The scaffold count register is five bits wide, so the active count never
  // exceeds thirty-one whatever the memory depth.
  localparam int MaxCnt = (MaxScaffolds < 31) ? MaxScaffolds : 31;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic       state_q, state_d;
  logic [4:0] scaffold_count_q;
  logic [4:0] act_cnt;
  logic [4:0] issue_cnt_q, issue_cnt_d;
  logic       rd_vld_q;
  status_e    status_q, status_d;

  logic       accept;
  logic       issue;
  logic       finish;

  label_t     entry_d;
  status_e    in_status;

  tbl_ctl_t   tbl_ctl;
  logic [AddrW+3:0] idx_wide;
  logic [AddrW+4:0] cnt_wide;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  label_t     rd_data;

  logic       scan_consistent;
  label_t     scan_cons;

  logic       out_valid_q;
  status_e    out_status_q;
  logic       out_consistent_q;
  label_t     out_label_q;

  // The scaffold count register; reset leaves one scaffold in use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scaffold_count_q <= 5'd1;
    end else if (scaffold_count_we_i) begin
      scaffold_count_q <= scaffold_count_i;
    end
  end

  assign act_cnt = (scaffold_count_q > 5'(MaxCnt)) ? 5'(MaxCnt) : scaffold_count_q;

  // Input checking. Types above beta are stored as OTHER, and every field
  // but the type is zero for a non-beta label.
  always_comb begin
    entry_d = '0;
    if (label_type_i > TYPE_BETA) begin
      entry_d.lbl_type = TYPE_OTHER;
    end else begin
      entry_d.lbl_type = label_type_i;
    end
    if (entry_d.lbl_type == TYPE_BETA) begin
      entry_d.partner_one = partner_one_i;
      entry_d.anti_one    = antiparallel_one_i;
      entry_d.partner_two = partner_two_i;
      entry_d.anti_two    = antiparallel_two_i;
      entry_d.sheet       = sheet_label_i;
    end

    // An index out of range is reported before a beta label without partner.
    if (!kind_i) begin
      in_status = STATUS_OK;
    end else if ({1'b0, entry_index_i} >= act_cnt) begin
      in_status = STATUS_RANGE;
    end else if ((entry_d.lbl_type == TYPE_BETA) &&
                 (partner_one_i == '0) && (partner_two_i == '0)) begin
      in_status = STATUS_NO_PARTNER;
    end else begin
      in_status = STATUS_OK;
    end
  end

  // Sequencer. The write happens at the accepting edge, so the scan that
  // follows always reads the updated table and no forwarding is needed.
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign issue      = (state_q == ST_SCAN) && (issue_cnt_q < act_cnt);
  assign finish     = (state_q == ST_SCAN) && !issue && !rd_vld_q &&
                      (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    issue_cnt_d = issue_cnt_q;
    status_d    = status_q;
    if (accept) begin
      state_d     = ST_SCAN;
      issue_cnt_d = '0;
      status_d    = in_status;
    end else if (issue) begin
      issue_cnt_d = issue_cnt_q + 5'd1;
    end else if (finish) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_cnt_q <= '0;
      rd_vld_q    <= 1'b0;
      status_q    <= STATUS_OK;
    end else begin
      state_q     <= state_d;
      issue_cnt_q <= issue_cnt_d;
      rd_vld_q    <= issue;
      status_q    <= status_d;
    end
  end

  // Memory control. A clear beat drops every valid bit, also those of
  // entries beyond the scaffold count.
  assign idx_wide = {{AddrW{1'b0}}, entry_index_i};
  assign cnt_wide = {{AddrW{1'b0}}, issue_cnt_q};
  assign wr_addr  = idx_wide[AddrW-1:0];
  assign rd_addr  = cnt_wide[AddrW-1:0];

  always_comb begin
    tbl_ctl.clr   = accept && !kind_i;
    tbl_ctl.wr_en = accept && kind_i && (in_status == STATUS_OK);
    tbl_ctl.rd_en = issue;
  end

  sct_table #(
    .MaxScaffolds(MaxScaffolds)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (tbl_ctl),
    .wr_addr_i(wr_addr),
    .wr_data_i(entry_d),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Consensus accumulation over the entries as they come back from memory.
  sct_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_i      (accept),
    .take_i      (rd_vld_q),
    .entry_i     (rd_data),
    .consistent_o(scan_consistent),
    .consensus_o (scan_cons)
  );

  // Result register. It parts the output from the sequencer so that the
  // next beat can be accepted while this one waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_status_q     <= status_q;
      out_consistent_q <= scan_consistent;
      out_label_q      <= scan_cons;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign status_o                = out_status_q;
  assign consistent_o            = out_consistent_q;
  assign consensus_type_o        = out_label_q.lbl_type;
  assign consensus_partner_one_o = out_label_q.partner_one;
  assign consensus_anti_one_o    = out_label_q.anti_one;
  assign consensus_partner_two_o = out_label_q.partner_two;
  assign consensus_anti_two_o    = out_label_q.anti_two;
  assign consensus_sheet_o       = out_label_q.sheet;

`include "structure_consensus_table_assert.svh"

  `SCT_ASSERT_SAME(a_no_write_in_scan, state_q == ST_SCAN, !tbl_ctl.wr_en, "table written during scan")
  `SCT_ASSERT_SAME(a_reject_no_write, accept && (in_status != STATUS_OK), !tbl_ctl.wr_en, "rejected store wrote the table")
  `SCT_ASSERT_SAME(a_scan_bound, state_q == ST_SCAN, issue_cnt_q <= act_cnt, "scan ran past the active count")
  `SCT_ASSERT_NEXT(a_finish_result, finish, out_valid_o && (state_q == ST_IDLE), "finished scan left no result")

endmodule
